[rtl/srl_pkg.sv]
package srl_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int LEN_W   = 6;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  localparam int FLAG_UP = 0;
  localparam int FLAG_GW = 1;

  localparam logic [1:0] PORT_NONE = 2'd0;

  // One table row. The prefix length is worked out once, when the row is appended.
  typedef struct packed {
    logic [31:0]      dest;
    logic [31:0]      mask;
    logic [31:0]      gateway;
    logic [2:0]       flags;
    logic             port;
    logic [7:0]       metric;
    logic [LEN_W-1:0] len;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] ones32(input logic [31:0] v);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = {1'b0, ones8(v[7:0])} + {1'b0, ones8(v[15:8])};
    hi = {1'b0, ones8(v[23:16])} + {1'b0, ones8(v[31:24])};
    return {1'b0, lo} + {1'b0, hi};
  endfunction

endpackage

[rtl/srl_row_ram.sv]
module srl_row_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/srl_ctrl.sv]
module srl_ctrl
  import srl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [31:0]      dest_ip,
  input  logic [31:0]      net_mask,
  input  logic [31:0]      gateway_ip,
  input  logic [2:0]       route_flags,
  input  logic             port_index,
  input  logic [7:0]       route_metric,
  input  logic [3:0]       position,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_port,
  output logic [31:0]      next_hop,
  output logic [1:0]       status,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output logic [ROW_W-1:0] ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  logic [ROW_W-1:0] ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DEL, S_RESULT} state_t;

  state_t           state;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] scan;
  logic             pend;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      ip;
  logic             found;
  logic [LEN_W-1:0] best_len;
  logic [1:0]       res_port;
  logic [31:0]      res_hop;
  logic [1:0]       res_status;

  logic             accept;
  logic             full;
  logic             pos_bad;
  logic             scan_live;
  logic             out_free;
  logic             row_hit;
  row_t             new_row;
  row_t             rd_row;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (row_count == CNT_W'(ENTRIES));
  assign pos_bad   = (CNT_W'(position) >= row_count);
  assign scan_live = (scan < row_count);
  assign out_free  = !out_valid || out_ready;
  assign rd_row    = row_t'(ram_rdata);

  always_comb begin
    new_row.dest    = dest_ip;
    new_row.mask    = net_mask;
    new_row.gateway = gateway_ip;
    new_row.flags   = route_flags;
    new_row.port    = port_index;
    new_row.metric  = route_metric;
    new_row.len     = ones32(net_mask);
  end

  assign row_hit = rd_row.flags[FLAG_UP] && ((ip & rd_row.mask) == rd_row.dest) &&
                   (!found || (rd_row.len > best_len));

  // An append writes straight from the input; a delete copies each later row up one place.
  always_comb begin
    if (state == S_IDLE) begin
      ram_we    = accept && (kind == KIND_APPEND) && !full;
      ram_waddr = row_count[IDX_W-1:0];
      ram_wdata = ROW_W'(new_row);
    end else begin
      ram_we    = (state == S_DEL) && pend;
      ram_waddr = wr_idx;
      ram_wdata = ram_rdata;
    end
  end

  assign ram_raddr = scan[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ip         <= dest_ip;
            res_port   <= PORT_NONE;
            res_hop    <= '0;
            found      <= 1'b0;
            best_len   <= '0;
            pend       <= 1'b0;
            unique case (kind)
              KIND_LOOKUP: begin
                res_status <= ST_OK;
                scan       <= '0;
                state      <= S_LOOK;
              end
              KIND_APPEND: begin
                state <= S_RESULT;
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  row_count  <= row_count + 1'b1;
                end
              end
              KIND_DELETE: begin
                if (pos_bad) begin
                  res_status <= ST_BADPOS;
                  state      <= S_RESULT;
                end else begin
                  res_status <= ST_OK;
                  scan       <= CNT_W'(position) + 1'b1;
                  state      <= S_DEL;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_RESULT;
              end
            endcase
          end
        end
        S_LOOK: begin
          pend <= scan_live;
          if (scan_live) begin
            scan <= scan + 1'b1;
          end
          if (pend && row_hit) begin
            found    <= 1'b1;
            best_len <= rd_row.len;
            res_port <= rd_row.port ? 2'd2 : 2'd1;
            res_hop  <= rd_row.flags[FLAG_GW] ? rd_row.gateway : ip;
          end
          if (!scan_live && !pend) begin
            state <= S_RESULT;
          end
        end
        S_DEL: begin
          pend   <= scan_live;
          wr_idx <= scan[IDX_W-1:0] - 1'b1;
          if (scan_live) begin
            scan <= scan + 1'b1;
          end
          if (!scan_live && !pend) begin
            row_count <= row_count - 1'b1;
            state     <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_port  <= res_port;
            next_hop  <= res_hop;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/static_route_lookup_top.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, dest_ip, net_mask, gateway_ip, route_flags,
//                                  port_index, route_metric, position
// output    out_valid / out_ready  out_port, next_hop, status
//
// A lookup reads the row memory one row per cycle; its read data is registered.
// A delete that moves rows copies each later row up one place, reading and writing
// the row memory through its read and write ports; deleting the last row moves none.
// Appends, bad deletes and unused kinds go directly to the result state.
// in_ready rises with out_valid.
// Reset empties the table at once; stored rows are not cleared.
// A stalled result holds in the output register while the next item is accepted.
module static_route_lookup_top
  import srl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] dest_ip,
  input  logic [31:0] net_mask,
  input  logic [31:0] gateway_ip,
  input  logic [2:0]  route_flags,
  input  logic        port_index,
  input  logic [7:0]  route_metric,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_port,
  output logic [31:0] next_hop,
  output logic [1:0]  status
);

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  srl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .dest_ip      (dest_ip),
    .net_mask     (net_mask),
    .gateway_ip   (gateway_ip),
    .route_flags  (route_flags),
    .port_index   (port_index),
    .route_metric (route_metric),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_port     (out_port),
    .next_hop     (next_hop),
    .status       (status),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  srl_row_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ROW_W)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[rtl/srl_checker.sv]
module srl_checker
  import srl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_port,
  input logic [31:0] next_hop,
  input logic [1:0]  status
);

  // A stalled item keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_port) && $stable(next_hop) &&
    $stable(status))
    else $error("result changed while stalled");

  // Error results never carry a route.
  a_err_no_route: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (out_port == PORT_NONE) && (next_hop == 32'd0))
    else $error("error result carries a route");

  // A miss always reports a zero next hop.
  a_miss_zero_hop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_port == PORT_NONE) |-> (next_hop == 32'd0))
    else $error("miss with nonzero next hop");

  a_codes_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3) && (out_port != 2'd3))
    else $error("illegal status or port code");

endmodule

bind static_route_lookup_top srl_checker u_srl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_port  (out_port),
  .next_hop  (next_hop),
  .status    (status)
);
